// ===== rtl/core/ipap_pkg.sv =====
// Shared types and constants for the IPv4 address and port parser.
package ipap_pkg;

  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharDot   = 8'h2E;
  localparam logic [7:0] CharColon = 8'h3A;

  localparam int unsigned ValueWidth = 20;  // field * 10 + 9 with a 16-bit field
  localparam logic [ValueWidth-1:0] OctetMax = ValueWidth'(255);
  localparam logic [ValueWidth-1:0] PortMax  = ValueWidth'(65535);

  localparam logic [2:0] LastOctetField = 3'd3;
  localparam logic [2:0] PortField      = 3'd4;

  typedef struct packed {
    logic [2:0]  field_index;
    logic        digit_seen;
    logic [15:0] field_value;
    logic [23:0] octets_so_far;
    logic [7:0]  fourth_octet;
    logic        bad_flag;
  } parser_state_t;

  typedef struct packed {
    logic        ok;
    logic [31:0] address;
    logic [15:0] port;
  } parse_result_t;

  localparam parser_state_t StateReset = '0;

endpackage

// ===== rtl/core/ipv4_address_port_parser_top.sv =====
// Top level of the IPv4 dotted-quad address and port parser.
// One character is taken per clock while in_ready_o is high, as the parse
// state advances once per accepted character. A transaction flagged last
// yields one result (ok, address, port), registered in a two-entry output
// stage (output register plus skid register) that lets input continue while
// a result waits; in_ready_o drops only when both hold undelivered results.
// Address and port read zero when ok is low.
module ipv4_address_port_parser_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        ok_o,
  output logic [31:0] address_o,
  output logic [15:0] port_o
);
  import ipap_pkg::*;

  parser_state_t state_q, state_d;
  parse_result_t step_result;
  parse_result_t out_q, skid_q;
  logic          out_valid_q, skid_valid_q;
  logic          in_fire, push, pop;

  ipap_step u_step (
    .state_i     (state_q),
    .character_i (character_i),
    .last_i      (last_i),
    .state_o     (state_d),
    .result_o    (step_result)
  );

  assign in_ready_o = !skid_valid_q;
  assign in_fire    = in_valid_i && in_ready_o;
  assign push       = in_fire && last_i;
  assign pop        = out_valid_q && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StateReset;
    end else if (in_fire) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (pop) begin
        skid_valid_q <= 1'b0;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (pop) begin
        out_q <= skid_q;
      end
    end else if (push) begin
      if (out_valid_q && !pop) begin
        skid_q <= step_result;
      end else begin
        out_q <= step_result;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign ok_o        = out_q.ok;
  assign address_o   = out_q.address;
  assign port_o      = out_q.port;

endmodule

// ===== rtl/core/ipap_step.sv =====
// Per-character parser step: next state and the result for a final character.
module ipap_step (
  input  ipap_pkg::parser_state_t state_i,
  input  logic [7:0]              character_i,
  input  logic                    last_i,
  output ipap_pkg::parser_state_t state_o,
  output ipap_pkg::parse_result_t result_o
);
  import ipap_pkg::*;

  parser_state_t          nxt;
  logic [ValueWidth-1:0]  value;
  logic [ValueWidth-1:0]  limit;
  logic [3:0]             digit;

  // ASCII '0'..'9' carry their digit in the low nibble
  assign digit = character_i[3:0];
  assign value = ValueWidth'(state_i.field_value) * ValueWidth'(10)
               + ValueWidth'(digit);
  assign limit = (state_i.field_index == PortField) ? PortMax : OctetMax;

  always_comb begin
    nxt = state_i;
    if (!state_i.bad_flag) begin
      if (character_i inside {[CharZero:CharNine]}) begin
        if (state_i.field_index > PortField || value > limit) begin
          nxt.bad_flag = 1'b1;
        end else begin
          nxt.field_value = value[15:0];
          nxt.digit_seen  = 1'b1;
        end
      end else if (character_i == CharDot) begin
        if (state_i.field_index < LastOctetField && state_i.digit_seen) begin
          nxt.octets_so_far = {state_i.octets_so_far[15:0], state_i.field_value[7:0]};
          nxt.field_index   = state_i.field_index + 3'd1;
          nxt.field_value   = '0;
          nxt.digit_seen    = 1'b0;
        end else begin
          nxt.bad_flag = 1'b1;
        end
      end else if (character_i == CharColon) begin
        if (state_i.field_index == LastOctetField && state_i.digit_seen) begin
          nxt.fourth_octet = state_i.field_value[7:0];
          nxt.field_index  = PortField;
          nxt.field_value  = '0;
          nxt.digit_seen   = 1'b0;
        end else begin
          nxt.bad_flag = 1'b1;
        end
      end else begin
        nxt.bad_flag = 1'b1;
      end
    end
  end

  always_comb begin
    result_o = '0;
    if (!nxt.bad_flag && nxt.digit_seen) begin
      if (nxt.field_index == LastOctetField) begin
        result_o.ok      = 1'b1;
        result_o.address = {nxt.octets_so_far, nxt.field_value[7:0]};
      end else if (nxt.field_index == PortField) begin
        result_o.ok      = 1'b1;
        result_o.address = {nxt.octets_so_far, nxt.fourth_octet};
        result_o.port    = nxt.field_value;
      end
    end
  end

  // a final character hands the string over and the parser starts afresh
  assign state_o = last_i ? StateReset : nxt;

endmodule

// ===== rtl/core/ipap_checker.sv =====
// Port-level checks for the address parser, bound to its top level.
module ipap_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic        last_i,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic        ok_o,
  input logic [31:0] address_o,
  input logic [15:0] port_o
);

  // a waiting result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(ok_o)
      && $stable(address_o) && $stable(port_o))
    else $error("stalled result changed");

  // a rejected string reports no address or port
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !ok_o |-> address_o == 32'd0 && port_o == 16'd0)
    else $error("bad string carries address or port");

  // a final character into an empty output stage shows up next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && last_i && !out_valid_o |=> out_valid_o)
    else $error("result missing after final character");

  // back-pressure only with results waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o)
    else $error("input stalled with no result pending");

endmodule

bind ipv4_address_port_parser_top ipap_checker u_ipap_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .last_i      (last_i),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .ok_o        (ok_o),
  .address_o   (address_o),
  .port_o      (port_o)
);

// ===== test/tb_ipv4_address_port_parser_top.sv =====
// Self-checking testbench for the IPv4 dotted-quad address and port parser.
module tb_ipv4_address_port_parser_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ipap_pkg::*;

  localparam int unsigned CycleLimit   = 400_000;
  localparam int unsigned RandomChars  = 700;
  localparam int unsigned HoldCycles   = 300;
  localparam int unsigned TailCycles   = 8;
  localparam int unsigned ReportLimit  = 10;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  logic [7:0]  character_i = '0;
  logic        last_i      = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        ok_o;
  logic [31:0] address_o;
  logic [15:0] port_o;

  ipv4_address_port_parser_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .character_i (character_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .ok_o        (ok_o),
    .address_o   (address_o),
    .port_o      (port_o)
  );

  always #10 clk_i = ~clk_i;

  // Parser shadow state
  logic [2:0]  field_idx   = '0;
  logic        has_digit   = 1'b0;
  logic [15:0] cur_value   = '0;
  logic [23:0] done_octets = '0;
  logic [7:0]  held_octet  = '0;
  logic        invalid     = 1'b0;

  parse_result_t pending_results[$];
  logic [7:0]    line_buf[$];

  int unsigned chars_parsed = 0;
  int unsigned fail_count   = 0;
  int unsigned cycle_count  = 0;
  bit          tx_steady    = 1'b0;
  bit          rx_steady    = 1'b0;
  bit          hold_req     = 1'b0;

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  function automatic void parse_character(logic [7:0] ch);
    logic [ValueWidth-1:0] v;
    logic [ValueWidth-1:0] limit;
    chars_parsed++;
    if (invalid) return;
    if (ch >= CharZero && ch <= CharNine) begin
      limit = (field_idx == PortField) ? PortMax : OctetMax;
      v = ValueWidth'(cur_value) * ValueWidth'(10) + ValueWidth'(ch - CharZero);
      if (field_idx > PortField || v > limit) begin
        invalid = 1'b1;
      end else begin
        cur_value = v[15:0];
        has_digit = 1'b1;
      end
    end else if (ch == CharDot) begin
      if (field_idx < LastOctetField && has_digit) begin
        done_octets = {done_octets[15:0], cur_value[7:0]};
        field_idx++;
        cur_value = '0;
        has_digit = 1'b0;
      end else begin
        invalid = 1'b1;
      end
    end else if (ch == CharColon) begin
      if (field_idx == LastOctetField && has_digit) begin
        held_octet = cur_value[7:0];
        field_idx  = PortField;
        cur_value  = '0;
        has_digit  = 1'b0;
      end else begin
        invalid = 1'b1;
      end
    end else begin
      invalid = 1'b1;
    end
  endfunction

  function automatic void close_string();
    parse_result_t r;
    r = '0;
    if (!invalid && has_digit) begin
      if (field_idx == LastOctetField) begin
        r.ok      = 1'b1;
        r.address = {done_octets, cur_value[7:0]};
      end else if (field_idx == PortField) begin
        r.ok      = 1'b1;
        r.address = {done_octets, held_octet};
        r.port    = cur_value;
      end
    end
    pending_results.push_back(r);
    field_idx   = '0;
    has_digit   = 1'b0;
    cur_value   = '0;
    done_octets = '0;
    held_octet  = '0;
    invalid     = 1'b0;
  endfunction

  function automatic void report_failure(string msg);
    if (fail_count < ReportLimit) $display("%s", msg);
    fail_count++;
  endfunction

  function automatic void append_number(int unsigned value);
    string s;
    if ($urandom_range(7) == 0) repeat ($urandom_range(3, 1)) line_buf.push_back(CharZero);
    s = $sformatf("%0d", value);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
  endfunction

  // Mostly well-formed addresses, a share deliberately broken in one way
  function automatic void build_address();
    int unsigned kind;
    int unsigned octets;
    int unsigned bad_pos;
    int unsigned value;
    kind   = $urandom_range(99);
    octets = 4;
    if (kind >= 70 && kind < 75) octets = $urandom_range(3, 1);
    else if (kind >= 75 && kind < 78) octets = 5;
    bad_pos = $urandom_range(octets - 1);
    for (int i = 0; i < octets; i++) begin
      if (i != 0) line_buf.push_back(CharDot);
      if (kind >= 78 && kind < 81 && i == bad_pos) continue;
      if (kind >= 81 && kind < 85 && i == bad_pos) begin
        value = $urandom_range(999, 256);
      end else begin
        case ($urandom_range(4))
          0:       value = 0;
          1:       value = 255;
          default: value = $urandom_range(255);
        endcase
      end
      append_number(value);
    end
    if ((kind >= 85 && kind < 91) || $urandom_range(1) == 0) begin
      line_buf.push_back(CharColon);
      if (kind >= 88 && kind < 91) begin
        append_number($urandom_range(99999, 65536));
      end else if (kind < 85 || kind >= 88) begin
        case ($urandom_range(4))
          0:       append_number(0);
          1:       append_number(65535);
          default: append_number($urandom_range(65535));
        endcase
      end
    end
    if (kind >= 91 && kind < 96)
      line_buf[$urandom_range(line_buf.size() - 1)] = 8'($urandom_range(255));
    else if (kind >= 96)
      line_buf.insert($urandom_range(line_buf.size() - 1), CharColon);
  endfunction

  function automatic void build_noise();
    repeat ($urandom_range(6, 1)) begin
      case ($urandom_range(3))
        0:       line_buf.push_back(CharDot);
        1:       line_buf.push_back(8'($urandom_range(CharNine, CharZero)));
        default: line_buf.push_back(8'($urandom_range(255)));
      endcase
    end
  endfunction

  // Sends the string in line_buf, one transaction per character
  task automatic send_line();
    int unsigned gap;
    bit          final_char;
    for (int i = 0; i < line_buf.size(); i++) begin
      gap        = tx_steady ? 0 : pick_gap();
      final_char = (i == line_buf.size() - 1);
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      in_valid_i  <= 1'b1;
      character_i <= line_buf[i];
      last_i      <= final_char;
      do @(posedge clk_i); while (!in_ready_o);
      parse_character(line_buf[i]);
      if (final_char) close_string();
    end
    line_buf.delete();
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) line_buf.push_back(s[i]);
    send_line();
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic test_extremes();
    send_text("0.0.0.0");
    send_text("255.255.255.255:65535");
    send_text("007.8.9.10:0");
    wait_for_results();
  endtask

  task automatic test_malformed();
    send_text("256");            // octet overflow
    send_text("9.9.9.9:65536");  // port overflow
    send_text("1.2.3.4:");       // empty port
    send_text("1..2");           // empty octet
    send_text(".");
    send_text(":");
    send_text("1.2.3.4.5");      // fourth dot
    send_text("1.2:3");          // colon too early
    send_text("9");              // ends before fourth octet
    send_text("[");
    line_buf.push_back(8'hFF);
    send_line();
    line_buf.push_back(8'h00);
    send_line();
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    int unsigned start;
    start = chars_parsed;
    while (chars_parsed - start < RandomChars) begin
      if ($urandom_range(9) == 0) build_noise();
      else build_address();
      send_line();
      if ($urandom_range(49) == 0) wait_for_results();
    end
    wait_for_results();
  endtask

  // Output held off for a long stretch while short strings keep arriving
  task automatic test_output_hold();
    hold_req  = 1'b1;
    tx_steady = 1'b1;
    repeat (30) begin
      if ($urandom_range(1) == 0) build_noise();
      else send_text("1.2.3.4");
      if (line_buf.size() != 0) send_line();
    end
    tx_steady = 1'b0;
    wait_for_results();
  endtask

  task automatic test_back_to_back();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    repeat (15) begin
      build_address();
      send_line();
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_for_results();
  endtask

  // Result consumer with random stalls and an on-demand long hold-off
  initial begin : result_sink
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_ready_i <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
        out_ready_i <= 1'b1;
      end else if (stall_left != 0) begin
        out_ready_i <= 1'b0;
        stall_left--;
      end else begin
        out_ready_i <= 1'b1;
        if (!rx_steady && $urandom_range(3) == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    parse_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        report_failure($sformatf("unexpected result: ok=%0b address=%08h port=%0d",
                                 ok_o, address_o, port_o));
      end else begin
        want = pending_results.pop_front();
        if (want.ok !== ok_o || want.address !== address_o || want.port !== port_o)
          report_failure($sformatf(
            "mismatch: expected ok=%0b address=%08h port=%0d, got ok=%0b address=%08h port=%0d",
            want.ok, want.address, want.port, ok_o, address_o, port_o));
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_extremes();
    test_malformed();
    test_random_traffic();
    test_output_hold();
    test_back_to_back();
    repeat (TailCycles) @(posedge clk_i);
    if (pending_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", pending_results.size()));
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
